[hdl/box_blur_3x3_edge_normalized_assert.svh]
// Assertion macros shared by the blur block's modules.
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bb3_pkg.sv]
// Types, constants and helper functions of the 3x3 box blur.
package bb3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Configuration port
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    localparam logic ACT_DRAIN = 1'b1;

    // Datapath widths
    localparam int COUNT_W     = 4;
    localparam int SUM_W       = 12;
    localparam int N_W         = 13;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 32;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic       action;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } out_word_t;

    // One accepted word on its way through the line stores and window
    typedef struct packed {
        logic               valid;
        logic               emit;
        logic               wrap;
        logic [2:0]         col_mask;
        logic [2:0]         row_mask;
        logic [COUNT_W-1:0] count;
        logic [RECIP_W-1:0] recip;
        logic               frame_end;
        rgb_t               pixel;
    } item_t;

    // Rounded numerators waiting for the scaling multiply
    typedef struct packed {
        logic               valid;
        logic [N_W-1:0]     n_red;
        logic [N_W-1:0]     n_green;
        logic [N_W-1:0]     n_blue;
        logic [RECIP_W-1:0] recip;
        logic               frame_end;
    } scale_t;

    function automatic int addr_bits(int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic [1:0] ones3(logic [2:0] m);
        return 2'(m[0]) + 2'(m[1]) + 2'(m[2]);
    endfunction

    // ceil(2^19 / (2*count)); exact floor division for numerators below 4600
    function automatic logic [RECIP_W-1:0] recip_of(logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1:    r = 19'd262144;
            4'd2:    r = 19'd131072;
            4'd3:    r = 19'd87382;
            4'd4:    r = 19'd65536;
            4'd6:    r = 19'd43691;
            4'd9:    r = 19'd29128;
            default: r = 19'd262144;
        endcase
        return r;
    endfunction

endpackage

[hdl/bb3_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module bb3_ram
    import bb3_pkg::*;
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = DEF_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [addr_bits(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         re,
    input  logic [addr_bits(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem_array [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read the old contents of the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/bb3_ctrl.sv]
// Configuration registers, position counters and per-word edge decisions.
`include "box_blur_3x3_edge_normalized_assert.svh"

module bb3_ctrl
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  reg_index_t                      cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    input  logic                            in_valid,
    input  in_word_t                        in_word,
    input  logic                            adv,
    output logic                            in_ready,
    output logic                            rd_en,
    output logic [addr_bits(MAX_WIDTH)-1:0] rd_addr,
    output item_t                           item,
    output logic [addr_bits(MAX_WIDTH)-1:0] item_addr
);

    localparam int COL_W = addr_bits(MAX_WIDTH);
    localparam int ORW   = addr_bits(MAX_HEIGHT);
    localparam int IRW   = addr_bits(MAX_HEIGHT + 2);
    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

    logic [COL_W-1:0] w_last_reg, w_last_next;
    logic [ORW-1:0]   h_last_reg, h_last_next;
    logic [COL_W-1:0] ic_reg, ic_next;
    logic [IRW-1:0]   ir_reg, ir_next;
    logic [COL_W-1:0] oc_reg, oc_next;
    logic [ORW-1:0]   orow_reg, orow_next;
    item_t            item_reg, item_next;
    logic [COL_W-1:0] addr_reg, addr_next;

    logic [WIDTH_REG_W-1:0]  wraw;
    logic [HEIGHT_REG_W-1:0] hraw;
    logic [COL_W-1:0]        w_clamp;
    logic [ORW-1:0]          h_clamp;
    logic                    accept;
    logic                    take;
    logic                    drop;
    logic                    emit;
    logic                    wrap;
    logic                    in_frame;
    logic                    col_last;
    logic                    row_last;
    logic                    frame_last;
    logic [2:0]              col_mask;
    logic [2:0]              row_mask;
    logic [COUNT_W-1:0]      count;

    // Clamp register writes to the supported frame size
    always_comb
    begin
        wraw = cfg_data[WIDTH_REG_W-1:0];
        hraw = cfg_data[HEIGHT_REG_W-1:0];
        if (wraw == '0)
            w_clamp = '0;
        else if (32'(wraw) > 32'(MAX_WIDTH))
            w_clamp = COL_W'(MAX_WIDTH - 1);
        else
            w_clamp = COL_W'(wraw - 1'b1);
        if (hraw == '0)
            h_clamp = '0;
        else if (32'(hraw) > 32'(MAX_HEIGHT))
            h_clamp = ORW'(MAX_HEIGHT - 1);
        else
            h_clamp = ORW'(hraw - 1'b1);
    end

    // Classify the offered word and pick the neighbourhood of the pixel it releases
    always_comb
    begin
        accept     = in_valid && adv;
        drop       = (in_word.action == ACT_DRAIN) && (ic_reg == '0) && (ir_reg == '0);
        take       = accept && !drop;
        in_frame   = ir_reg <= IRW'(h_last_reg);
        emit       = (ir_reg >= IRW'(2)) || ((ir_reg == IRW'(1)) && (ic_reg != '0));
        wrap       = ic_reg == '0;
        col_last   = oc_reg == w_last_reg;
        row_last   = orow_reg == h_last_reg;
        frame_last = col_last && row_last;
        if (wrap)
            col_mask = {1'b1, oc_reg != '0, 1'b0};
        else
            col_mask = {!col_last, 1'b1, oc_reg != '0};
        row_mask = {!row_last, 1'b1, orow_reg != '0};
        count    = COUNT_W'(ones3(col_mask)) * COUNT_W'(ones3(row_mask));
    end

    // Advance counters and load the next pipeline word
    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        ic_next     = ic_reg;
        ir_next     = ir_reg;
        oc_next     = oc_reg;
        orow_next   = orow_reg;
        item_next   = item_reg;
        addr_next   = addr_reg;

        if (take)
        begin
            if (emit)
            begin
                if (frame_last)
                begin
                    oc_next   = '0;
                    orow_next = '0;
                end
                else if (col_last)
                begin
                    oc_next   = '0;
                    orow_next = orow_reg + 1'b1;
                end
                else
                begin
                    oc_next = oc_reg + 1'b1;
                end
            end
            if (emit && frame_last)
            begin
                ic_next = '0;
                ir_next = '0;
            end
            else if (ic_reg == w_last_reg)
            begin
                ic_next = '0;
                ir_next = ir_reg + 1'b1;
            end
            else
            begin
                ic_next = ic_reg + 1'b1;
            end
        end

        if (adv)
        begin
            item_next.valid     = take;
            item_next.emit      = emit;
            item_next.wrap      = wrap;
            item_next.col_mask  = col_mask;
            item_next.row_mask  = row_mask;
            item_next.count     = count;
            item_next.recip     = recip_of(count);
            item_next.frame_end = frame_last;
            if ((in_word.action != ACT_DRAIN) && in_frame)
                item_next.pixel = {in_word.red_in, in_word.green_in, in_word.blue_in};
            else
                item_next.pixel = '0;
            addr_next = ic_reg;
        end

        // Any register write restarts the frame
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  w_last_next = w_clamp;
                REG_IMAGE_HEIGHT: h_last_next = h_clamp;
                default:          w_last_next = w_last_reg;
            endcase
            ic_next   = '0;
            ir_next   = '0;
            oc_next   = '0;
            orow_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= COL_W'(RST_W - 1);
            h_last_reg <= ORW'(RST_H - 1);
            ic_reg     <= '0;
            ir_reg     <= '0;
            oc_reg     <= '0;
            orow_reg   <= '0;
            item_reg   <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
            ic_reg     <= ic_next;
            ir_reg     <= ir_next;
            oc_reg     <= oc_next;
            orow_reg   <= orow_next;
            item_reg   <= item_next;
            addr_reg   <= addr_next;
        end
    end

    assign in_ready  = adv;
    assign rd_en     = take;
    assign rd_addr   = ic_reg;
    assign item      = item_reg;
    assign item_addr = addr_reg;

    `BB3_ASSERT_NOW(a_in_col_range, clk, rst_n, 1'b1, ic_reg <= w_last_reg, "input column past row end")
    `BB3_ASSERT_NOW(a_out_row_range, clk, rst_n, 1'b1, orow_reg <= h_last_reg, "output row past frame")
    `BB3_ASSERT_NEXT(a_frame_restart, clk, rst_n, take && emit && frame_last, (ic_reg == '0) && (ir_reg == '0) && (oc_reg == '0) && (orow_reg == '0), "frame end did not restart positions")

endmodule

[hdl/bb3_window.sv]
// Line stores with read-modify-write forwarding, 3x3 window and masked sums.
module bb3_window
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  item_t                           item,
    input  logic [addr_bits(MAX_WIDTH)-1:0] item_addr,
    input  logic                            rd_en,
    input  logic [addr_bits(MAX_WIDTH)-1:0] rd_addr,
    output scale_t                          stage
);

    rgb_t   upper_rdata;
    rgb_t   lower_rdata;
    rgb_t   top_eff;
    rgb_t   mid_eff;
    logic   wr_en;
    logic   fwd_reg, fwd_next;
    rgb_t   fwd_top_reg, fwd_top_next;
    rgb_t   fwd_mid_reg, fwd_mid_next;
    rgb_t   win_reg [0:8];
    rgb_t   win_next [0:8];
    rgb_t   shifted [0:8];
    rgb_t   view [0:8];
    logic [9:0]     col_red [0:2];
    logic [9:0]     col_green [0:2];
    logic [9:0]     col_blue [0:2];
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    scale_t stage_reg, stage_next;

    assign wr_en = adv && item.valid;

    // Upper store takes the old middle row, lower store the new pixel
    bb3_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_upper_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (item_addr),
        .wdata (mid_eff),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (upper_rdata)
    );

    bb3_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_lower_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (item_addr),
        .wdata (item.pixel),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (lower_rdata)
    );

    // Forward the word being written when the next read hits the same column
    always_comb
    begin
        top_eff      = fwd_reg ? fwd_top_reg : upper_rdata;
        mid_eff      = fwd_reg ? fwd_mid_reg : lower_rdata;
        fwd_next     = fwd_reg;
        fwd_top_next = fwd_top_reg;
        fwd_mid_next = fwd_mid_reg;
        if (rd_en)
        begin
            fwd_next     = wr_en && (item_addr == rd_addr);
            fwd_top_next = mid_eff;
            fwd_mid_next = item.pixel;
        end
    end

    // Shift the window by one column; wrap words look at the unshifted one
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            shifted[i] = win_reg[i + 3];
        end
        shifted[6] = top_eff;
        shifted[7] = mid_eff;
        shifted[8] = item.pixel;
        for (int i = 0; i < 9; i++)
        begin
            view[i]     = item.wrap ? win_reg[i] : shifted[i];
            win_next[i] = wr_en ? shifted[i] : win_reg[i];
        end
    end

    // Sum the in-image cells, column by column
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            col_red[c]   = '0;
            col_green[c] = '0;
            col_blue[c]  = '0;
            for (int r = 0; r < 3; r++)
            begin
                if (item.col_mask[c] && item.row_mask[r])
                begin
                    col_red[c]   = col_red[c] + 10'(view[c * 3 + r].red);
                    col_green[c] = col_green[c] + 10'(view[c * 3 + r].green);
                    col_blue[c]  = col_blue[c] + 10'(view[c * 3 + r].blue);
                end
            end
        end
        sum_red   = SUM_W'(col_red[0]) + SUM_W'(col_red[1]) + SUM_W'(col_red[2]);
        sum_green = SUM_W'(col_green[0]) + SUM_W'(col_green[1]) + SUM_W'(col_green[2]);
        sum_blue  = SUM_W'(col_blue[0]) + SUM_W'(col_blue[1]) + SUM_W'(col_blue[2]);
    end

    // Hold the rounding numerators 2*sum + count for the scaler
    always_comb
    begin
        stage_next = stage_reg;
        if (adv)
        begin
            stage_next.valid     = item.valid && item.emit;
            stage_next.n_red     = N_W'({sum_red, 1'b0}) + N_W'(item.count);
            stage_next.n_green   = N_W'({sum_green, 1'b0}) + N_W'(item.count);
            stage_next.n_blue    = N_W'({sum_blue, 1'b0}) + N_W'(item.count);
            stage_next.recip     = item.recip;
            stage_next.frame_end = item.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg     <= 1'b0;
            fwd_top_reg <= '0;
            fwd_mid_reg <= '0;
            stage_reg   <= '0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            fwd_reg     <= fwd_next;
            fwd_top_reg <= fwd_top_next;
            fwd_mid_reg <= fwd_mid_next;
            stage_reg   <= stage_next;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    assign stage = stage_reg;

endmodule

[hdl/bb3_scale.sv]
// Reciprocal multiply that rounds the means, and the output word register.
`include "box_blur_3x3_edge_normalized_assert.svh"

module bb3_scale
    import bb3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scale_t    stage,
    input  logic      out_ready,
    output logic      adv,
    output logic      out_valid,
    output out_word_t out_word
);

    logic [PROD_W-1:0] prod_red;
    logic [PROD_W-1:0] prod_green;
    logic [PROD_W-1:0] prod_blue;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    // floor((2*sum + count) / (2*count)) by multiply and shift
    always_comb
    begin
        prod_red   = PROD_W'(stage.n_red) * PROD_W'(stage.recip);
        prod_green = PROD_W'(stage.n_green) * PROD_W'(stage.recip);
        prod_blue  = PROD_W'(stage.n_blue) * PROD_W'(stage.recip);
    end

    // Advance the pipeline whenever the output register is free or drains
    always_comb
    begin
        adv            = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (adv)
        begin
            out_valid_next = stage.valid;
            if (stage.valid)
            begin
                out_word_next.red_out   = prod_red[RECIP_SHIFT +: 8];
                out_word_next.green_out = prod_green[RECIP_SHIFT +: 8];
                out_word_next.blue_out  = prod_blue[RECIP_SHIFT +: 8];
                out_word_next.frame_end = stage.frame_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `BB3_ASSERT_NOW(a_mean_fits, clk, rst_n, stage.valid, (prod_red[PROD_W-1:RECIP_SHIFT+8] == '0) && (prod_green[PROD_W-1:RECIP_SHIFT+8] == '0) && (prod_blue[PROD_W-1:RECIP_SHIFT+8] == '0), "rounded mean exceeds 8 bits")

endmodule

[hdl/box_blur_3x3_edge_normalized.sv]
// 3x3 box blur of a raster-order RGB stream, normalized at the image edges.
//
// Takes one word per clock and holds that rate as long as the output side
// takes results; a held output word freezes the whole pipeline and drops
// in_ready until it is taken. The edge that accepts the word
// releasing a result registers it and starts the line store read;
// the window update and masked sum are registered after it, then
// the reciprocal multiply into the output register. The line
// stores are two RAMs of MAX_WIDTH pixels, each read and written
// once per word, with forwarding when one row column is revisited
// back to back (one-pixel-wide images); they need no clearing after reset.
// The blurred pixel k of a frame comes out on input word k + width + 1, so
// follow each frame with width + 1 drain words; the last pixel carries
// frame_end. A drain word at frame start is dropped, a drain word inside the
// frame counts as a black pixel. Writing either size register restarts the
// frame; write only while the block is idle.
module box_blur_3x3_edge_normalized
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  reg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word
);

    localparam int COL_W = addr_bits(MAX_WIDTH);

    logic             adv;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    item_t            item;
    logic [COL_W-1:0] item_addr;
    scale_t           stage;

    bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .adv       (adv),
        .in_ready  (in_ready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .item      (item),
        .item_addr (item_addr)
    );

    bb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .item      (item),
        .item_addr (item_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .stage     (stage)
    );

    bb3_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .out_ready (out_ready),
        .adv       (adv),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule
